>>> design/event_channel_sleep_wakeup_assert.svh
// Assertion macros shared by the wait-channel block.
`ifndef EVENT_CHANNEL_SLEEP_WAKEUP_ASSERT_SVH
`define EVENT_CHANNEL_SLEEP_WAKEUP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ECSW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECSW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ecsw_pkg.sv
// Package: constants, codes and beat types of the wait-channel block.
package ecsw_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int MAX_SLEEPERS = 8;
    localparam int TASK_ID_BITS = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int OP_W      = 2;
    localparam int CHAN_W    = 4;
    localparam int TASK_W    = 8;
    localparam int PENDING_W = 16;

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int SLP_IDX_W = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLEEPERS + 1);
    localparam int MEM_DEPTH = NUM_CHANNELS * MAX_SLEEPERS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_WAKEUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_WAKE  = 2'd2
    } action_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t                     op;
        logic [CHAN_W-1:0]       chan;
        logic                    in_range;
        logic [TASK_ID_BITS-1:0] tid;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [CHAN_W-1:0] chan_out;
        action_t           action;
        logic [TASK_W-1:0] task_out;
        logic              last;
    } result_t;

endpackage

>>> design/ecsw_front.sv
// Front end: takes input beats and classifies them into commands.
module ecsw_front
    import ecsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [CHAN_W-1:0] chan_w;

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
    assign chan_w    = s_tdata[OP_W +: CHAN_W];

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            valid_next        = 1'b1;
            cmd_next.op       = op_t'(s_tdata[OP_W-1:0]);
            cmd_next.chan     = chan_w;
            cmd_next.in_range = int'(chan_w) < NUM_CHANNELS;
            cmd_next.tid      = TASK_ID_BITS'(s_tdata[OP_W + CHAN_W +: TASK_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

>>> design/ecsw_queue.sv
// Short command queue between front and back.
module ecsw_queue
    import ecsw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/ecsw_back.sv
// Back end: channel table, sleeper memory, wake sequencer and result register.
`include "event_channel_sleep_wakeup_assert.svh"

module ecsw_back
    import ecsw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    typedef enum logic {
        S_IDLE,
        S_WAKE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 res_reg;
    result_t                 res_next;

    logic [NUM_CHANNELS-1:0] live_reg;
    logic [NUM_CHANNELS-1:0] live_next;
    logic [PENDING_W-1:0]    pend_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]        cnt_reg  [NUM_CHANNELS];

    logic [CH_W-1:0]         wk_idx_reg;
    logic [CH_W-1:0]         wk_idx_next;
    logic [CHAN_W-1:0]       wk_chan_reg;
    logic [CHAN_W-1:0]       wk_chan_next;
    logic [CNT_W-1:0]        wk_k_reg;
    logic [CNT_W-1:0]        wk_k_next;
    logic [CNT_W-1:0]        wk_n_reg;
    logic [CNT_W-1:0]        wk_n_next;

    logic [TASK_ID_BITS-1:0] mem [MEM_DEPTH];
    logic [TASK_ID_BITS-1:0] rd_data_reg;
    logic                    mem_we;
    logic [MEM_AW-1:0]       mem_waddr;
    logic                    mem_re;
    logic [MEM_AW-1:0]       mem_raddr;

    logic                    pend_we;
    logic [CH_W-1:0]         pend_widx;
    logic [PENDING_W-1:0]    pend_wdata;
    logic                    cnt_we;
    logic [CH_W-1:0]         cnt_widx;
    logic [CNT_W-1:0]        cnt_wdata;

    logic                    out_free;
    logic [CH_W-1:0]         cidx;
    logic                    ch_ok;
    logic [PENDING_W-1:0]    pend_cur;
    logic [CNT_W-1:0]        cnt_cur;
    logic                    free_found;
    logic [CH_W-1:0]         free_idx;
    logic                    wk_last;

    function automatic logic [MEM_AW-1:0] slot_addr(input logic [CH_W-1:0] idx,
                                                    input logic [SLP_IDX_W-1:0] k);
        slot_addr = MEM_AW'(idx) * MEM_AW'(MAX_SLEEPERS) + MEM_AW'(k);
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;
    assign cidx      = CH_W'(cmd.chan);
    assign ch_ok     = cmd.in_range && live_reg[cidx];
    assign pend_cur  = pend_reg[cidx];
    assign cnt_cur   = cnt_reg[cidx];
    assign wk_last   = (wk_k_reg + 1'b1) == wk_n_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = NUM_CHANNELS - 1; s >= 0; s--)
        begin
            if (!live_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = CH_W'(s);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        live_next      = live_reg;
        wk_idx_next    = wk_idx_reg;
        wk_chan_next   = wk_chan_reg;
        wk_k_next      = wk_k_reg;
        wk_n_next      = wk_n_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr(cidx, SLP_IDX_W'(cnt_cur));
        mem_re         = 1'b0;
        mem_raddr      = slot_addr(cidx, '0);
        pend_we        = 1'b0;
        pend_widx      = cidx;
        pend_wdata     = '0;
        cnt_we         = 1'b0;
        cnt_widx       = cidx;
        cnt_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop           = 1'b1;
                    out_valid_next    = 1'b1;
                    res_next.status   = ST_DONE;
                    res_next.chan_out = cmd.chan;
                    res_next.action   = ACT_NONE;
                    res_next.task_out = '0;
                    res_next.last     = 1'b1;
                    case (cmd.op)
                        OP_CREATE:
                        begin
                            if (free_found)
                            begin
                                live_next[free_idx] = 1'b1;
                                pend_we             = 1'b1;
                                pend_widx           = free_idx;
                                cnt_we              = 1'b1;
                                cnt_widx            = free_idx;
                                res_next.chan_out   = CHAN_W'(free_idx);
                            end
                            else
                            begin
                                res_next.status   = ST_ERROR;
                                res_next.chan_out = '0;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!ch_ok || cnt_cur != '0)
                            begin
                                res_next.status = ST_ERROR;
                            end
                            else
                            begin
                                live_next[cidx] = 1'b0;
                                pend_we         = 1'b1;
                            end
                        end
                        OP_SLEEP:
                        begin
                            if (!ch_ok)
                            begin
                                res_next.status = ST_ERROR;
                            end
                            else if (pend_cur != '0)
                            begin
                                pend_we         = 1'b1;
                                pend_wdata      = pend_cur - 1'b1;
                                res_next.status = ST_PENDING;
                            end
                            else if (cnt_cur >= CNT_W'(MAX_SLEEPERS))
                            begin
                                res_next.status = ST_ERROR;
                            end
                            else
                            begin
                                mem_we            = 1'b1;
                                cnt_we            = 1'b1;
                                cnt_wdata         = cnt_cur + 1'b1;
                                res_next.action   = ACT_BLOCK;
                                res_next.task_out = TASK_W'(cmd.tid);
                            end
                        end
                        OP_WAKEUP:
                        begin
                            if (!ch_ok)
                            begin
                                res_next.status = ST_ERROR;
                            end
                            else if (cnt_cur == '0)
                            begin
                                pend_we         = 1'b1;
                                pend_wdata      = (pend_cur == '1) ? pend_cur : pend_cur + 1'b1;
                                res_next.status = ST_PENDING;
                            end
                            else
                            begin
                                // results come from the sleeper memory, one per cycle while the output is free
                                out_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                cnt_we         = 1'b1;
                                wk_idx_next    = cidx;
                                wk_chan_next   = cmd.chan;
                                wk_k_next      = '0;
                                wk_n_next      = cnt_cur;
                                state_next     = S_WAKE;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_ERROR;
                        end
                    endcase
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    res_next.status   = ST_DONE;
                    res_next.chan_out = wk_chan_reg;
                    res_next.action   = ACT_WAKE;
                    res_next.task_out = TASK_W'(rd_data_reg);
                    res_next.last     = wk_last;
                    if (wk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wk_k_next = wk_k_reg + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = slot_addr(wk_idx_reg, SLP_IDX_W'(wk_k_reg + 1'b1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            wk_idx_reg    <= '0;
            wk_chan_reg   <= '0;
            wk_k_reg      <= '0;
            wk_n_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            wk_idx_reg    <= wk_idx_next;
            wk_chan_reg   <= wk_chan_next;
            wk_k_reg      <= wk_k_next;
            wk_n_reg      <= wk_n_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pend_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            live_reg <= live_next;
            if (pend_we)
            begin
                pend_reg[pend_widx] <= pend_wdata;
            end
            if (cnt_we)
            begin
                cnt_reg[cnt_widx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.tid;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `ECSW_ASSERT_IMP(a_wake_idx_bound, state_reg == S_WAKE, wk_k_reg < wk_n_reg, "wake index past sleeper count")
    `ECSW_ASSERT_IMP(a_no_pop_in_wake, state_reg == S_WAKE, !cmd_pop, "command taken during wake run")
    `ECSW_ASSERT_IMP(a_sleep_write_bound, mem_we, cnt_we && cnt_wdata <= CNT_W'(MAX_SLEEPERS), "sleeper queue overrun")
    `ECSW_ASSERT_NXT(a_wake_last_ends, state_reg == S_WAKE && out_free && wk_last, state_reg == S_IDLE && res_reg.last, "wake run did not end on last")

endmodule

>>> design/event_channel_sleep_wakeup.sv
// Top level: wait-channel table with sleep and wakeup.
//
//   bus | dir | tdata fields (lsb up)                            | tlast
//   s   | in  | op[1:0] channel_id[5:2] task_id[13:6], pad 15:14 | -
//   m   | out | status[1:0] chan_out[5:2] action[7:6] task_out[15:8] | last
//
// An item goes from s beat to m beat via front register, queue and back.
// While m is free, back executes one item per cycle; a wakeup with n sleepers
// gives n beats, one a cycle, from the sleeper memory, taking no item meanwhile.
// Reset clears the channel table at once; no clearing pass.
// The queue lets s keep taking beats while m is stalled, until it fills.
module event_channel_sleep_wakeup
    import ecsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op, channel_id, task_id, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status, chan_out, action, task_out
    output logic        m_tlast
);

    logic    f_valid;
    logic    f_ready;
    cmd_t    f_cmd;
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    ecsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    ecsw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_cmd)
    );

    ecsw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {res.task_out, res.action, res.chan_out, res.status};
    assign m_tlast = res.last;

endmodule
